// ----- hw/rtl/dst_pkg.sv -----
// Shared constants, register map and result tag type for the diffusion stencil.
// No dependencies; every other file of the block imports this package.

package dst_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_VALUE_BITS = 16;

  // Fixed field widths
  localparam int GAIN_W      = 16;
  localparam int COLS_CFG_W  = 11;
  localparam int ROWS_CFG_W  = 13;
  localparam int COL_IDX_W   = 10;
  localparam int ROW_W       = 12;
  localparam int MAX_ROWS    = 4096;
  localparam int MIN_GRID    = 2;

  // Fixed point: gains are Q0.16, results rounded to nearest
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(3);

  localparam logic [GAIN_W-1:0]     GAIN_RESET = GAIN_W'(8192);
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(1024);
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(1024);

  // Position and flags that travel with each result through the arithmetic
  typedef struct packed {
    logic [COL_IDX_W-1:0] col_index;
    logic [ROW_W-1:0]     row_index;
    logic                 grid_done;
    logic                 run_last;
  } res_tag_t;

endpackage

// ----- hw/rtl/dst_if.sv -----
// Valid/ready channel interfaces: grid point feed, updated point results, config writes.
// Depends on dst_pkg for widths.

interface dst_feed_if
  import dst_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] conc_in;

  modport source (output valid, output conc_in, input ready);
  modport sink   (input valid, input conc_in, output ready);
endinterface

interface dst_result_if
  import dst_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [COL_IDX_W-1:0]  col_index;
  logic [ROW_W-1:0]      row_index;
  logic [VALUE_BITS-1:0] conc_out;
  logic                  grid_done;
  logic                  run_last;

  modport source (output valid, output col_index, output row_index, output conc_out,
                  output grid_done, output run_last, input ready);
  modport sink   (input valid, input col_index, input row_index, input conc_out,
                  input grid_done, input run_last, output ready);
endinterface

interface dst_cfg_if
  import dst_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/diffusion_stencil_2d.sv -----
// Top level of the 2-D explicit diffusion stencil: config registers and wiring.
// Depends on dst_pkg, dst_if, dst_sched and dst_stencil.
//
//   channel  role    accepted when          carries
//   feed     sink    feed.valid & ready     conc_in, one grid point in raster order
//   result   source  result.valid & ready   col_index, row_index, conc_out, grid_done, run_last
//   cfg      sink    cfg.valid & ready      index, data (gain_x, gain_y, grid_cols, grid_rows)
//
// A point sits in the input stage after its transfer; each of its results is one
// combinational pass into the result register, the first shown once it has passed both.
// Row 0 gives no results, later rows one per point, the last row two (one at column 0,
// three at its final column); the feed holds until a point's last result is registered.
// Reset (rst, synchronous) clears position, pending results and config; line buffers
// need no clearing. A stalled result holds the result register and the point behind it.

module diffusion_stencil_2d
  import dst_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst,
  dst_feed_if.sink     feed,
  dst_result_if.source result,
  dst_cfg_if.sink      cfg
);

  localparam int COL_W = $clog2(MAX_COLS);

  logic [GAIN_W-1:0]     gain_x;
  logic [GAIN_W-1:0]     gain_y;
  logic [COLS_CFG_W-1:0] grid_cols;
  logic [ROWS_CFG_W-1:0] grid_rows;
  logic [COL_W-1:0]      last_col;
  logic [ROW_W-1:0]      last_row_idx;

  logic                  op_valid;
  logic                  op_ready;
  logic [VALUE_BITS-1:0] op_c;
  logic [VALUE_BITS-1:0] op_l;
  logic [VALUE_BITS-1:0] op_r;
  logic [VALUE_BITS-1:0] op_d;
  logic [VALUE_BITS-1:0] op_u;
  res_tag_t              op_tag;

  assign cfg.ready = !rst;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x    <= GAIN_RESET;
      gain_y    <= GAIN_RESET;
      grid_cols <= COLS_RESET;
      grid_rows <= ROWS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_GAIN_X:    gain_x    <= cfg.data[GAIN_W-1:0];
        REG_GAIN_Y:    gain_y    <= cfg.data[GAIN_W-1:0];
        REG_GRID_COLS: grid_cols <= cfg.data[COLS_CFG_W-1:0];
        REG_GRID_ROWS: grid_rows <= cfg.data[ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp grid size to the supported range and form the last indices
  always_comb begin
    if (32'(grid_cols) >= 32'(MAX_COLS)) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else if (grid_cols < COLS_CFG_W'(MIN_GRID)) begin
      last_col = COL_W'(MIN_GRID - 1);
    end else begin
      last_col = COL_W'(grid_cols - COLS_CFG_W'(1));
    end
    if (32'(grid_rows) >= 32'(MAX_ROWS)) begin
      last_row_idx = ROW_W'(MAX_ROWS - 1);
    end else if (grid_rows < ROWS_CFG_W'(MIN_GRID)) begin
      last_row_idx = ROW_W'(MIN_GRID - 1);
    end else begin
      last_row_idx = ROW_W'(grid_rows - ROWS_CFG_W'(1));
    end
  end

  dst_sched #(
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_sched (
    .clk          (clk),
    .rst          (rst),
    .feed         (feed),
    .last_col     (last_col),
    .last_row_idx (last_row_idx),
    .op_valid     (op_valid),
    .op_ready     (op_ready),
    .op_c         (op_c),
    .op_l         (op_l),
    .op_r         (op_r),
    .op_d         (op_d),
    .op_u         (op_u),
    .op_tag       (op_tag)
  );

  dst_stencil #(
    .VALUE_BITS (VALUE_BITS)
  ) u_stencil (
    .clk      (clk),
    .rst      (rst),
    .gain_x   (gain_x),
    .gain_y   (gain_y),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op_c     (op_c),
    .op_l     (op_l),
    .op_r     (op_r),
    .op_d     (op_d),
    .op_u     (op_u),
    .op_tag   (op_tag),
    .result   (result)
  );

endmodule

// ----- hw/rtl/dst_sched.sv -----
// Raster position counters, the two line buffers and the result sequencer.
// Depends on dst_pkg and dst_feed_if; feeds operand sets to dst_stencil.

module dst_sched
  import dst_pkg::*;
#(
  parameter int  MAX_COLS   = DEF_MAX_COLS,
  parameter int  VALUE_BITS = DEF_VALUE_BITS,
  localparam int COL_W      = $clog2(MAX_COLS)
) (
  input  logic                  clk,
  input  logic                  rst,
  dst_feed_if.sink              feed,
  input  logic [COL_W-1:0]      last_col,
  input  logic [ROW_W-1:0]      last_row_idx,
  output logic                  op_valid,
  input  logic                  op_ready,
  output logic [VALUE_BITS-1:0] op_c,
  output logic [VALUE_BITS-1:0] op_l,
  output logic [VALUE_BITS-1:0] op_r,
  output logic [VALUE_BITS-1:0] op_d,
  output logic [VALUE_BITS-1:0] op_u,
  output res_tag_t              op_tag
);

  // Line buffers, indexed by column
  logic [VALUE_BITS-1:0] row_one_back [MAX_COLS];
  logic [VALUE_BITS-1:0] row_two_back [MAX_COLS];

  logic [VALUE_BITS-1:0] one_rd_a;
  logic [VALUE_BITS-1:0] one_rd_b;
  logic [VALUE_BITS-1:0] two_rd;
  logic [VALUE_BITS-1:0] one_left;

  logic [COL_W-1:0]      col_count;
  logic [ROW_W-1:0]      row_count;
  logic [COL_W-1:0]      col_plus1;
  logic [COL_W-1:0]      s1_col;
  logic [ROW_W-1:0]      s1_row;
  logic                  s1_row_end;
  logic [2:0]            s1_mask;
  logic [2:0]            mask_next;
  logic                  two_wr_pend;

  // rec0 is the newest input, rec1 and rec2 the two before it
  logic [VALUE_BITS-1:0] rec0;
  logic [VALUE_BITS-1:0] rec1;
  logic [VALUE_BITS-1:0] rec2;

  logic                  accept;
  logic                  issue;
  logic                  s1_free;
  logic                  row_end;
  logic                  last_row;

  // Result bits in s1_mask, emitted lowest first
  localparam int RES_UP   = 0;  // point of the previous row
  localparam int RES_BACK = 1;  // last row, one point behind
  localparam int RES_END  = 2;  // last row, final column

  assign row_end   = col_count >= last_col;
  assign last_row  = row_count >= last_row_idx;
  assign col_plus1 = col_count + COL_W'(1);

  assign op_valid  = |s1_mask;
  assign issue     = op_valid && op_ready;
  assign mask_next = s1_mask & (s1_mask - 3'd1);
  assign s1_free   = !op_valid || (issue && (mask_next == 3'd0));
  assign feed.ready = s1_free && !rst;
  assign accept    = feed.valid && feed.ready;

  // Previous row: write the new point, read its old value and the next column
  always_ff @(posedge clk) begin
    if (accept) begin
      row_one_back[col_count] <= feed.conc_in;
      one_rd_a                <= row_one_back[col_count];
      one_rd_b                <= row_one_back[col_plus1];
    end
  end

  // Row before that: read at accept, refill in the next cycle from the old previous row
  always_ff @(posedge clk) begin
    if (accept) begin
      two_rd <= row_two_back[col_count];
    end
    if (two_wr_pend) begin
      row_two_back[s1_col] <= one_rd_a;
    end
  end

  // Hold the item in service and the left neighbor read for the item before it
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= col_count;
      s1_row     <= row_count;
      s1_row_end <= row_end;
      one_left   <= one_rd_a;
    end
  end

  // Advance raster position, input history and pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      s1_mask     <= '0;
      two_wr_pend <= 1'b0;
      rec0        <= '0;
      rec1        <= '0;
      rec2        <= '0;
    end else begin
      two_wr_pend <= accept;
      if (accept) begin
        if (row_end) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_plus1;
        end
        rec2 <= rec1;
        rec1 <= rec0;
        rec0 <= feed.conc_in;
        s1_mask[RES_UP]   <= row_count != '0;
        s1_mask[RES_BACK] <= last_row && (col_count != '0);
        s1_mask[RES_END]  <= last_row && row_end;
      end else if (issue) begin
        s1_mask <= mask_next;
      end
    end
  end

  // Pick the five stencil points for the lowest pending result
  always_comb begin
    op_c = rec0;
    op_l = rec1;
    op_r = rec1;
    op_d = one_rd_a;
    op_u = one_rd_a;
    op_tag.col_index = COL_IDX_W'(s1_col);
    op_tag.row_index = s1_row;
    op_tag.grid_done = 1'b1;
    op_tag.run_last  = mask_next == 3'd0;
    if (s1_mask[RES_UP]) begin
      op_c = one_rd_a;
      op_l = (s1_col == '0) ? one_rd_b : one_left;
      op_r = s1_row_end ? one_left : one_rd_b;
      op_d = (s1_row == ROW_W'(1)) ? rec0 : two_rd;
      op_u = rec0;
      op_tag.row_index = s1_row - ROW_W'(1);
      op_tag.grid_done = 1'b0;
    end else if (s1_mask[RES_BACK]) begin
      op_c = rec1;
      op_l = (s1_col == COL_W'(1)) ? rec0 : rec2;
      op_r = rec0;
      op_d = one_left;
      op_u = one_left;
      op_tag.col_index = COL_IDX_W'(s1_col - COL_W'(1));
      op_tag.grid_done = 1'b0;
    end
  end

endmodule

// ----- hw/rtl/dst_stencil.sv -----
// Stencil arithmetic: Laplacian terms, gain products, round and saturate into the result register.
// Depends on dst_pkg and dst_result_if; the result register is its only stage.

module dst_stencil
  import dst_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [GAIN_W-1:0]     gain_x,
  input  logic [GAIN_W-1:0]     gain_y,
  input  logic                  op_valid,
  output logic                  op_ready,
  input  logic [VALUE_BITS-1:0] op_c,
  input  logic [VALUE_BITS-1:0] op_l,
  input  logic [VALUE_BITS-1:0] op_r,
  input  logic [VALUE_BITS-1:0] op_d,
  input  logic [VALUE_BITS-1:0] op_u,
  input  res_tag_t              op_tag,
  dst_result_if.source          result
);

  localparam int LAP_W  = VALUE_BITS + 2;
  localparam int PROD_W = LAP_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QUO_W  = SUM_W - FRAC_BITS;

  // Second differences
  logic signed [LAP_W-1:0]  lap_x;
  logic signed [LAP_W-1:0]  lap_y;

  // Gain products
  logic signed [PROD_W-1:0] gx_ext;
  logic signed [PROD_W-1:0] gy_ext;
  logic signed [PROD_W-1:0] lx_ext;
  logic signed [PROD_W-1:0] ly_ext;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;

  // Sum, round and clamp
  logic signed [SUM_W-1:0]  base_s;
  logic signed [SUM_W-1:0]  sum_s;
  logic [QUO_W-1:0]         quo;
  logic [VALUE_BITS-1:0]    conc_sat;

  // Result register
  logic                     res_valid;
  logic [VALUE_BITS-1:0]    res_conc;
  res_tag_t                 res_tag;

  // Take a new operand set when the result register is empty or drains
  assign op_ready = !res_valid || result.ready;

  assign lap_x = $signed(LAP_W'(op_l) + LAP_W'(op_r) - (LAP_W'(op_c) << 1));
  assign lap_y = $signed(LAP_W'(op_d) + LAP_W'(op_u) - (LAP_W'(op_c) << 1));

  assign gx_ext = PROD_W'(gain_x);
  assign gy_ext = PROD_W'(gain_y);
  assign lx_ext = PROD_W'(lap_x);
  assign ly_ext = PROD_W'(lap_y);
  assign prod_x = gx_ext * lx_ext;
  assign prod_y = gy_ext * ly_ext;

  // Old value in Q.16, plus both terms, plus half an LSB
  assign base_s = SUM_W'({op_c, {FRAC_BITS{1'b0}}});
  assign sum_s  = base_s + SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(ROUND_HALF);
  assign quo    = sum_s[SUM_W-1:FRAC_BITS];

  // Clamp negatives to zero and overflow to full scale
  always_comb begin
    if (quo[QUO_W-1]) begin
      conc_sat = '0;
    end else if (|quo[QUO_W-2:VALUE_BITS]) begin
      conc_sat = '1;
    end else begin
      conc_sat = quo[VALUE_BITS-1:0];
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (op_ready) begin
      res_valid <= op_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (op_ready && op_valid) begin
      res_conc <= conc_sat;
      res_tag  <= op_tag;
    end
  end

  assign result.valid     = res_valid;
  assign result.conc_out  = res_conc;
  assign result.col_index = res_tag.col_index;
  assign result.row_index = res_tag.row_index;
  assign result.grid_done = res_tag.grid_done;
  assign result.run_last  = res_tag.run_last;

endmodule

// ----- hw/rtl/dst_checker.sv -----
// Port-level assertions for the diffusion stencil, bound to the top level.
// Depends on dst_pkg; watches only the top level's ports.

module dst_checker
  import dst_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COL_IDX_W-1:0]  out_col,
  input logic [ROW_W-1:0]      out_row,
  input logic [VALUE_BITS-1:0] out_conc,
  input logic                  out_done,
  input logic                  out_last
);

  // A stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_conc) && $stable(out_col)
      && $stable(out_row) && $stable(out_done) && $stable(out_last))
    else $error("result changed while stalled");

  // Nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // The final point of a grid is always the last result of its point
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_last)
    else $error("grid_done without run_last");

  // Results of one point leave back to back
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a run of results");

endmodule

bind diffusion_stencil_2d dst_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_dst_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_col   (result.col_index),
  .out_row   (result.row_index),
  .out_conc  (result.conc_out),
  .out_done  (result.grid_done),
  .out_last  (result.run_last)
);
